[sv/mbd_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbd_pkg
// Shared constants and types of the multi-button debounce event mapper.
// ----------------------------------------------------------------------------
package mbd_pkg;

   localparam int NUM_SLOTS  = 8;
   localparam int TIME_WIDTH = 32;

   // only slots with a bound bit can act
   localparam int SCAN_SLOTS = (NUM_SLOTS < 8) ? NUM_SLOTS : 8;
   localparam int SLOT_W     = (SCAN_SLOTS > 1) ? $clog2(SCAN_SLOTS) : 1;

   localparam int NOW_W      = 32;
   localparam int MASK_W     = 8;
   localparam int WINDOW_W   = 16;
   localparam int MAP_W      = 16;
   localparam int CODE_W     = 2;
   localparam int SLOT_IDX_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 4;

   localparam logic [WINDOW_W-1:0] DEBOUNCE_RESET = 16'd40;

   localparam logic [1:0] REG_WINDOW = 2'd0;
   localparam logic [1:0] REG_BOUND  = 2'd1;
   localparam logic [1:0] REG_MAP    = 2'd2;

   typedef struct packed {
      logic                  confirmed;
      logic                  pending;
      logic [TIME_WIDTH-1:0] start_ms;
   } entry_type;

endpackage

[sv/mbd_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbd_req_if / mbd_rsp_if
// Valid/ready channels for poll samples and emitted events.
// ----------------------------------------------------------------------------
interface mbd_req_if;
   logic                        valid;
   logic                        ready;
   logic [mbd_pkg::NOW_W-1:0]   now_ms;
   logic [mbd_pkg::MASK_W-1:0]  pressed_bits;
   logic [mbd_pkg::MASK_W-1:0]  available_mask;

   modport source (output valid, now_ms, pressed_bits, available_mask, input ready);
   modport sink   (input valid, now_ms, pressed_bits, available_mask, output ready);
endinterface

interface mbd_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [mbd_pkg::CODE_W-1:0]      event_code;
   logic [mbd_pkg::SLOT_IDX_W-1:0]  slot_index;
   logic                            last_event;

   modport source (output valid, event_code, slot_index, last_event, input ready);
   modport sink   (input valid, event_code, slot_index, last_event, output ready);
endinterface

[sv/multi_button_debounce_event_mapper.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multi_button_debounce_event_mapper
// Time-window debouncer over bound button slots; committed presses emit
// their mapped event code in ascending slot order, last one flagged.
//
//   channel  dir  handshake        word
//   req      in   valid/ready      now_ms, pressed_bits, available_mask
//   rsp      out  valid/ready      event_code, slot_index, last_event
//   csr      in   APB write/read   debounce_window_ms, bound_mask, event_map
//
// A poll sweeps the slot state RAM (one read and, for an active slot, one
// write-back per cycle), then emits its events in ST_EMIT. The next poll is
// taken once the last event sits in the output register, or once the sweep
// ends if there is none. Reset is synchronous; slot state reads as released
// and idle until first written (per-slot valid bits). A stalled rsp holds the
// event sweep; the RAM scan itself never stalls.
// ----------------------------------------------------------------------------
module multi_button_debounce_event_mapper (
   input  logic                               clock,
   input  logic                               reset,
   mbd_req_if.sink                            req,
   mbd_rsp_if.source                          rsp,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [mbd_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [mbd_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [mbd_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                               csr_pready
);

   localparam int SCAN_SLOTS = mbd_pkg::SCAN_SLOTS;
   localparam int SLOT_W     = mbd_pkg::SLOT_W;
   localparam int TIME_WIDTH = mbd_pkg::TIME_WIDTH;
   localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(SCAN_SLOTS - 1);

   typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_EMIT} state_type;

   state_type                       state_ff, state_in;
   logic [SLOT_W-1:0]               slot_ff, slot_in;
   logic [SCAN_SLOTS-1:0]           emit_ff, emit_in;
   logic [SCAN_SLOTS-1:0]           valid_ff, valid_in;
   logic                            ent_valid_ff, ent_valid_in;
   logic [TIME_WIDTH-1:0]           now_ff, now_in;
   logic [mbd_pkg::MASK_W-1:0]      pressed_ff, pressed_in;
   logic [mbd_pkg::MASK_W-1:0]      avail_ff, avail_in;

   logic [mbd_pkg::WINDOW_W-1:0]    window_ff, window_in;
   logic [mbd_pkg::MASK_W-1:0]      bound_ff, bound_in;
   logic [mbd_pkg::MAP_W-1:0]       map_ff, map_in;

   logic                            rsp_valid_ff, rsp_valid_in;
   logic [mbd_pkg::CODE_W-1:0]      rsp_code_ff, rsp_code_in;
   logic [mbd_pkg::SLOT_IDX_W-1:0]  rsp_slot_ff, rsp_slot_in;
   logic                            rsp_last_ff, rsp_last_in;

   logic                            ram_wr_en, ram_rd_en;
   logic [SLOT_W-1:0]               ram_rd_addr;
   mbd_pkg::entry_type              ram_wr_data, ram_rd_data, ent;

   logic                            accept, csr_write, rsp_free;
   logic                            active, level, conf, pend, commit;
   logic [TIME_WIDTH-1:0]           held;
   logic [SLOT_W-1:0]               first_slot;
   logic [SCAN_SLOTS-1:0]           rest;
   logic [1:0]                      csr_index;

   mbd_ram #(
      .WIDTH ($bits(mbd_pkg::entry_type)),
      .DEPTH (SCAN_SLOTS)
   ) u_state_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (slot_ff),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign accept     = req.valid && req.ready;
   assign req.ready  = (state_ff == ST_IDLE);
   assign rsp_free   = !rsp_valid_ff || rsp.ready;
   assign csr_index  = csr_paddr[mbd_pkg::CSR_ADDR_W-1:2];
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;

   assign rsp.valid      = rsp_valid_ff;
   assign rsp.event_code = rsp_code_ff;
   assign rsp.slot_index = rsp_slot_ff;
   assign rsp.last_event = rsp_last_ff;

   always_comb begin
      unique case (csr_index)
         mbd_pkg::REG_WINDOW: csr_prdata = mbd_pkg::CSR_DATA_W'(window_ff);
         mbd_pkg::REG_BOUND:  csr_prdata = mbd_pkg::CSR_DATA_W'(bound_ff);
         mbd_pkg::REG_MAP:    csr_prdata = mbd_pkg::CSR_DATA_W'(map_ff);
         default:             csr_prdata = '0;
      endcase
   end

   // per-slot decision on the entry just read
   always_comb begin
      ent    = ram_rd_data;
      active = bound_ff[slot_ff] && avail_ff[slot_ff];
      level  = pressed_ff[slot_ff];
      conf   = ent_valid_ff && ent.confirmed;
      pend   = ent_valid_ff && ent.pending;
      held   = now_ff - ent.start_ms;
      commit = 1'b0;
      ram_wr_data.confirmed = conf;
      ram_wr_data.pending   = 1'b0;
      ram_wr_data.start_ms  = ent.start_ms;
      if (level != conf) begin
         if (!pend) begin
            ram_wr_data.pending  = 1'b1;
            ram_wr_data.start_ms = now_ff;
            commit = (window_ff == '0);
         end else begin
            ram_wr_data.pending = 1'b1;
            commit = (held >= TIME_WIDTH'(window_ff));
         end
         if (commit) begin
            ram_wr_data.confirmed = level;
            ram_wr_data.pending   = 1'b0;
         end
      end
   end

   // lowest pending event
   always_comb begin
      first_slot = '0;
      for (int i = SCAN_SLOTS - 1; i >= 0; i--) begin
         if (emit_ff[i]) begin
            first_slot = SLOT_W'(i);
         end
      end
      rest = emit_ff;
      rest[first_slot] = 1'b0;
   end

   always_comb begin
      state_in     = state_ff;
      slot_in      = slot_ff;
      emit_in      = emit_ff;
      valid_in     = valid_ff;
      ent_valid_in = ent_valid_ff;
      now_in       = now_ff;
      pressed_in   = pressed_ff;
      avail_in     = avail_ff;
      window_in    = window_ff;
      bound_in     = bound_ff;
      map_in       = map_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_code_in  = rsp_code_ff;
      rsp_slot_in  = rsp_slot_ff;
      rsp_last_in  = rsp_last_ff;
      ram_wr_en    = 1'b0;
      ram_rd_en    = 1'b0;
      ram_rd_addr  = '0;

      if (csr_write) begin
         unique case (csr_index)
            mbd_pkg::REG_WINDOW: window_in = csr_pwdata[mbd_pkg::WINDOW_W-1:0];
            mbd_pkg::REG_BOUND:  bound_in  = csr_pwdata[mbd_pkg::MASK_W-1:0];
            mbd_pkg::REG_MAP:    map_in    = csr_pwdata[mbd_pkg::MAP_W-1:0];
            default: ;
         endcase
      end

      if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               now_in      = TIME_WIDTH'(req.now_ms);
               pressed_in  = req.pressed_bits;
               avail_in    = req.available_mask;
               slot_in     = '0;
               ram_rd_en   = 1'b1;
               ram_rd_addr = '0;
               state_in    = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (active) begin
               ram_wr_en         = 1'b1;
               valid_in[slot_ff] = 1'b1;
               emit_in[slot_ff]  = commit && level;
            end
            if (slot_ff != SLOT_LAST) begin
               ram_rd_en   = 1'b1;
               ram_rd_addr = slot_ff + 1'b1;
               slot_in     = slot_ff + 1'b1;
            end else if (emit_in == '0) begin
               state_in = ST_IDLE;
            end else begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_code_in  = map_ff[2 * first_slot +: mbd_pkg::CODE_W];
               rsp_slot_in  = mbd_pkg::SLOT_IDX_W'(first_slot);
               rsp_last_in  = (rest == '0);
               emit_in      = rest;
               if (rest == '0) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase

      if (ram_rd_en) begin
         ent_valid_in = valid_in[ram_rd_addr] && valid_ff[ram_rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         slot_ff      <= '0;
         emit_ff      <= '0;
         valid_ff     <= '0;
         ent_valid_ff <= 1'b0;
         window_ff    <= mbd_pkg::DEBOUNCE_RESET;
         bound_ff     <= '0;
         map_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         slot_ff      <= slot_in;
         emit_ff      <= emit_in;
         valid_ff     <= valid_in;
         ent_valid_ff <= ent_valid_in;
         window_ff    <= window_in;
         bound_ff     <= bound_in;
         map_ff       <= map_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      now_ff      <= now_in;
      pressed_ff  <= pressed_in;
      avail_ff    <= avail_in;
      rsp_code_ff <= rsp_code_in;
      rsp_slot_ff <= rsp_slot_in;
      rsp_last_ff <= rsp_last_in;
   end

   a_emit_nonempty: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_EMIT |-> emit_ff != '0)
      else $error("event sweep running with nothing queued");

   a_more_events: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_last_ff |-> state_ff == ST_EMIT)
      else $error("non-final event word with no event left to send");

   a_no_port_clash: assert property (@(posedge clock) disable iff (reset)
      ram_wr_en && ram_rd_en |-> ram_rd_addr != slot_ff)
      else $error("state RAM read and write hit the same slot");

   a_accept_clean: assert property (@(posedge clock) disable iff (reset)
      accept |-> emit_ff == '0)
      else $error("poll accepted while events from the last one remain");

   a_scan_length: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SCAN && slot_ff != SLOT_LAST |=> state_ff == ST_SCAN)
      else $error("slot sweep left early");

endmodule

[sv/mbd_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbd_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module mbd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 8
) (
   input  logic                                        clock,
   input  logic                                        wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                            wr_data,
   input  logic                                        rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                            rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[dv/multi_button_debounce_event_mapper_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multi_button_debounce_event_mapper_test
// Self-checking bench for the multi-button debounce event mapper. A directed
// table covers reset state, zero and maximum windows, cancel, unbinding,
// unavailable slots, timestamp wrap and an out-of-range register write; then
// random phases under several register settings drive bouncing button
// levels. Every poll is run through a slot-state model and each emitted word
// is compared in order. Sender bursts, receiver stalls and one long receiver
// hold-off exercise backpressure.
// ----------------------------------------------------------------------------
module multi_button_debounce_event_mapper_test;

   localparam logic [1:0] REG_SPARE     = 2'd3;
   localparam int         HOLD_CYCLES   = 400;
   localparam int         SETTLE_CYCLES = 40;

   typedef enum logic [1:0] {
      EV_START, EV_STOP_EARLY, EV_RERECORD, EV_STOP_SESSION
   } event_code_type;

   typedef enum logic [1:0] {ROW_POLL, ROW_TYPED, ROW_CSR} row_kind_type;
   typedef enum int {RX_FREE, RX_CHOPPY, RX_SPARSE} rx_mode_type;

   typedef struct packed {
      logic [mbd_pkg::CODE_W-1:0]     code;
      logic [mbd_pkg::SLOT_IDX_W-1:0] slot;
      logic                           last;
   } slot_event_type;

   typedef struct {
      row_kind_type                   kind;
      logic [1:0]                     reg_idx;
      logic [mbd_pkg::CSR_DATA_W-1:0] value;
      logic [mbd_pkg::NOW_W-1:0]      now;
      logic [mbd_pkg::MASK_W-1:0]     pressed;
      logic [mbd_pkg::MASK_W-1:0]     avail;
      int                             n_due;
      event_code_type                 code;
      logic [mbd_pkg::SLOT_IDX_W-1:0] slot;
   } stim_row_type;

   logic                           clock;
   logic                           reset;
   logic                           csr_psel;
   logic                           csr_penable;
   logic                           csr_pwrite;
   logic [mbd_pkg::CSR_ADDR_W-1:0] csr_paddr;
   logic [mbd_pkg::CSR_DATA_W-1:0] csr_pwdata;
   logic [mbd_pkg::CSR_DATA_W-1:0] csr_prdata;
   logic                           csr_pready;

   mbd_req_if req_ch ();
   mbd_rsp_if rsp_ch ();

   multi_button_debounce_event_mapper DUT (
      .clock       (clock),
      .reset       (reset),
      .req         (req_ch),
      .rsp         (rsp_ch),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // slot-state model
   logic [mbd_pkg::WINDOW_W-1:0] window_ms;
   logic [mbd_pkg::MASK_W-1:0]   bound_bits;
   logic [mbd_pkg::MAP_W-1:0]    code_map;
   logic                         level_q   [mbd_pkg::SCAN_SLOTS];
   logic                         pending_q [mbd_pkg::SCAN_SLOTS];
   logic [mbd_pkg::NOW_W-1:0]    since_ms  [mbd_pkg::SCAN_SLOTS];

   slot_event_type slot_hits[$];
   slot_event_type events_due[$];
   stim_row_type   directed_rows[$];
   int             mismatches = 0;
   int             burst_left = 0;
   bit             hold_armed = 1'b0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("*** FAILED ***");
      $finish;
   end

   function automatic void add_due(input slot_event_type w);
      events_due.insert(events_due.size(), w);
   endfunction

   function automatic void add_row(input stim_row_type r);
      directed_rows.insert(directed_rows.size(), r);
   endfunction

   function automatic void apply_register(input logic [1:0] idx,
                                          input logic [mbd_pkg::CSR_DATA_W-1:0] value);
      case (idx)
         mbd_pkg::REG_WINDOW: window_ms  = value[mbd_pkg::WINDOW_W-1:0];
         mbd_pkg::REG_BOUND:  bound_bits = value[mbd_pkg::MASK_W-1:0];
         mbd_pkg::REG_MAP:    code_map   = value[mbd_pkg::MAP_W-1:0];
         default: ;
      endcase
   endfunction

   function automatic void scan_slots(input logic [mbd_pkg::NOW_W-1:0] now,
                                      input logic [mbd_pkg::MASK_W-1:0] pressed,
                                      input logic [mbd_pkg::MASK_W-1:0] avail);
      logic                      level;
      logic                      commit;
      logic [mbd_pkg::NOW_W-1:0] held;
      slot_event_type            hit;
      slot_hits.delete();
      for (int s = 0; s < mbd_pkg::SCAN_SLOTS; s++) begin
         if (!bound_bits[s] || !avail[s]) continue;
         level = pressed[s];
         if (level == level_q[s]) begin
            pending_q[s] = 1'b0;
            continue;
         end
         if (!pending_q[s]) begin
            pending_q[s] = 1'b1;
            since_ms[s]  = now;
            commit       = (window_ms == '0);
         end else begin
            held   = now - since_ms[s];
            commit = (held >= mbd_pkg::NOW_W'(window_ms));
         end
         if (!commit) continue;
         level_q[s]   = level;
         pending_q[s] = 1'b0;
         if (level) begin
            hit = '{code_map[2*s +: mbd_pkg::CODE_W], mbd_pkg::SLOT_IDX_W'(s), 1'b0};
            slot_hits.insert(slot_hits.size(), hit);
         end
      end
      if (slot_hits.size() != 0)
         slot_hits[slot_hits.size()-1].last = 1'b1;
   endfunction

   function automatic stim_row_type poll_row(input logic [mbd_pkg::NOW_W-1:0] now,
                                             input logic [mbd_pkg::MASK_W-1:0] pressed,
                                             input logic [mbd_pkg::MASK_W-1:0] avail);
      stim_row_type r;
      r = '{ROW_POLL, mbd_pkg::REG_WINDOW, '0, now, pressed, avail, 0, EV_START, '0};
      return r;
   endfunction

   function automatic stim_row_type typed_row(input logic [mbd_pkg::NOW_W-1:0] now,
                                              input logic [mbd_pkg::MASK_W-1:0] pressed,
                                              input logic [mbd_pkg::MASK_W-1:0] avail,
                                              input int n_due, input event_code_type code,
                                              input logic [mbd_pkg::SLOT_IDX_W-1:0] slot);
      stim_row_type r;
      r = '{ROW_TYPED, mbd_pkg::REG_WINDOW, '0, now, pressed, avail, n_due, code, slot};
      return r;
   endfunction

   function automatic stim_row_type csr_row(input logic [1:0] idx,
                                            input logic [mbd_pkg::CSR_DATA_W-1:0] value);
      stim_row_type r;
      r = '{ROW_CSR, idx, value, '0, '0, '0, 0, EV_START, '0};
      return r;
   endfunction

   task automatic send_poll(input logic [mbd_pkg::NOW_W-1:0] now,
                            input logic [mbd_pkg::MASK_W-1:0] pressed,
                            input logic [mbd_pkg::MASK_W-1:0] avail);
      req_ch.valid          <= 1'b1;
      req_ch.now_ms         <= now;
      req_ch.pressed_bits   <= pressed;
      req_ch.available_mask <= avail;
      do @(posedge clock); while (!req_ch.ready);
   endtask

   task automatic idle_between();
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         burst_left = $urandom_range(0, 24);
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
   endtask

   task automatic csr_write(input logic [1:0] idx,
                            input logic [mbd_pkg::CSR_DATA_W-1:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      apply_register(idx, value);
   endtask

   task automatic csr_release();
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   // no word outstanding, then let any silent poll finish its scan
   task automatic settle_block();
      req_ch.valid <= 1'b0;
      while (events_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic run_phase(input logic [mbd_pkg::WINDOW_W-1:0] window,
                            input logic [mbd_pkg::MASK_W-1:0] bound,
                            input logic [mbd_pkg::MAP_W-1:0] map,
                            input logic [mbd_pkg::NOW_W-1:0] start_ms,
                            input int polls, input bit squeeze);
      logic [mbd_pkg::NOW_W-1:0]  now;
      logic [mbd_pkg::MASK_W-1:0] held;
      logic [mbd_pkg::MASK_W-1:0] pressed;
      logic [mbd_pkg::MASK_W-1:0] avail;
      int                         w;
      settle_block();
      csr_write(mbd_pkg::REG_WINDOW, {16'b0, window});
      csr_write(mbd_pkg::REG_BOUND, {24'b0, bound});
      csr_write(mbd_pkg::REG_MAP, {16'b0, map});
      csr_release();
      if (squeeze) hold_armed = 1'b1;
      now  = start_ms;
      held = 8'($urandom);
      w    = window;
      repeat (polls) begin
         case ($urandom_range(0, 9))
            0:       now = $urandom;
            1, 2, 3: now += $urandom_range(0, w / 4 + 1);
            default: now += w + $urandom_range(0, 4) - 2;
         endcase
         if ($urandom_range(0, 3) == 0) held = 8'($urandom);
         pressed = held;
         if ($urandom_range(0, 2) == 0) pressed ^= 8'($urandom & $urandom);
         avail = ($urandom_range(0, 5) == 0) ? 8'($urandom) : 8'hFF;
         send_poll(now, pressed, avail);
         scan_slots(now, pressed, avail);
         foreach (slot_hits[k]) add_due(slot_hits[k]);
         idle_between();
      end
   endtask

   // receiver: free, choppy and sparse stretches, plus one long hold-off
   initial begin
      rx_mode_type mode;
      int          left;
      mode = RX_FREE;
      left = 0;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_armed) begin
            rsp_ch.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_armed = 1'b0;
         end else begin
            if (left == 0) begin
               mode = rx_mode_type'($urandom_range(0, 2));
               left = $urandom_range(4, 60);
            end
            left--;
            case (mode)
               RX_FREE:   rsp_ch.ready <= 1'b1;
               RX_CHOPPY: rsp_ch.ready <= ($urandom_range(0, 3) != 0);
               default:   rsp_ch.ready <= ($urandom_range(0, 4) == 0);
            endcase
         end
      end
   end

   always @(posedge clock) begin
      slot_event_type due;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (events_due.size() == 0) begin
            mismatches++;
            $display("%0t: unexpected word: expected none, got code %0d slot %0d last %0d",
                     $time, rsp_ch.event_code, rsp_ch.slot_index, rsp_ch.last_event);
         end else begin
            due = events_due.pop_front();
            if (rsp_ch.event_code !== due.code || rsp_ch.slot_index !== due.slot ||
                rsp_ch.last_event !== due.last) begin
               mismatches++;
               $display("%0t: word mismatch: expected code %0d slot %0d last %0d,",
                        $time, due.code, due.slot, due.last);
               $display("%0t:   got code %0d slot %0d last %0d", $time,
                        rsp_ch.event_code, rsp_ch.slot_index, rsp_ch.last_event);
            end
         end
      end
   end

   initial begin
      stim_row_type   row;
      slot_event_type typed_word;
      bit             csr_open;

      reset                 <= 1'b1;
      req_ch.valid          <= 1'b0;
      req_ch.now_ms         <= '0;
      req_ch.pressed_bits   <= '0;
      req_ch.available_mask <= '0;
      csr_psel              <= 1'b0;
      csr_penable           <= 1'b0;
      csr_pwrite            <= 1'b0;
      csr_paddr             <= '0;
      csr_pwdata            <= '0;

      window_ms  = mbd_pkg::DEBOUNCE_RESET;
      bound_bits = '0;
      code_map   = '0;
      for (int s = 0; s < mbd_pkg::SCAN_SLOTS; s++) begin
         level_q[s]   = 1'b0;
         pending_q[s] = 1'b0;
         since_ms[s]  = '0;
      end
      csr_open = 1'b0;

      // nothing bound after reset
      add_row(typed_row(32'd0, 8'hFF, 8'hFF, 0, EV_START, 3'd0));
      // window from high bits only reads as zero; spare index is ignored
      add_row(csr_row(mbd_pkg::REG_WINDOW, 32'h0001_0000));
      add_row(csr_row(mbd_pkg::REG_BOUND, 32'h0000_00FF));
      add_row(csr_row(mbd_pkg::REG_MAP, 32'h0000_E4E4));
      add_row(csr_row(REG_SPARE, 32'hFFFF_FFFF));
      add_row(poll_row(32'd1, 8'hFF, 8'hFF));
      add_row(typed_row(32'd2, 8'h00, 8'hFF, 0, EV_START, 3'd0));
      add_row(typed_row(32'd3, 8'h01, 8'h00, 0, EV_START, 3'd0));
      add_row(typed_row(32'd4, 8'h80, 8'h80, 1, EV_STOP_SESSION, 3'd7));
      add_row(typed_row(32'd5, 8'h00, 8'hFF, 0, EV_START, 3'd0));
      // timestamp wrap across a 40 ms window
      add_row(csr_row(mbd_pkg::REG_WINDOW, 32'd40));
      add_row(csr_row(mbd_pkg::REG_BOUND, 32'h0000_0001));
      add_row(typed_row(32'hFFFF_FFF0, 8'h01, 8'h01, 0, EV_START, 3'd0));
      add_row(typed_row(32'h0000_0010, 8'h01, 8'h01, 0, EV_START, 3'd0));
      add_row(typed_row(32'h0000_0018, 8'h01, 8'h01, 1, EV_START, 3'd0));
      // cancel, then a silent release
      add_row(typed_row(32'h0000_0020, 8'h00, 8'h01, 0, EV_START, 3'd0));
      add_row(typed_row(32'h0000_0021, 8'h01, 8'h01, 0, EV_START, 3'd0));
      add_row(typed_row(32'h0000_0100, 8'h00, 8'h01, 0, EV_START, 3'd0));
      add_row(typed_row(32'h0000_0200, 8'h00, 8'h01, 0, EV_START, 3'd0));
      // pending press survives unbinding
      add_row(typed_row(32'h0000_0300, 8'h01, 8'h01, 0, EV_START, 3'd0));
      add_row(csr_row(mbd_pkg::REG_BOUND, 32'h0000_0000));
      add_row(typed_row(32'h0000_0400, 8'h01, 8'hFF, 0, EV_START, 3'd0));
      add_row(csr_row(mbd_pkg::REG_BOUND, 32'h0000_0001));
      add_row(csr_row(mbd_pkg::REG_WINDOW, 32'h0000_FFFF));
      add_row(csr_row(mbd_pkg::REG_MAP, 32'h0000_FFFF));
      add_row(typed_row(32'h0000_0400, 8'h01, 8'h01, 0, EV_START, 3'd0));
      add_row(typed_row(32'h0001_02FF, 8'h01, 8'h01, 1, EV_STOP_SESSION, 3'd0));
      add_row(csr_row(mbd_pkg::REG_WINDOW, 32'd0));
      add_row(csr_row(mbd_pkg::REG_BOUND, 32'h0000_00FF));
      add_row(csr_row(mbd_pkg::REG_MAP, 32'h0000_0000));
      add_row(poll_row(32'h7FFF_FFFF, 8'hAA, 8'hFF));
      add_row(poll_row(32'hFFFF_FFFF, 8'h55, 8'h55));

      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i]) begin
         row = directed_rows[i];
         if (row.kind == ROW_CSR) begin
            if (!csr_open) begin
               settle_block();
               csr_open = 1'b1;
            end
            csr_write(row.reg_idx, row.value);
         end else begin
            if (csr_open) begin
               csr_release();
               csr_open = 1'b0;
            end
            send_poll(row.now, row.pressed, row.avail);
            scan_slots(row.now, row.pressed, row.avail);
            if (row.kind == ROW_TYPED) begin
               if (row.n_due != 0) begin
                  typed_word = '{row.code, row.slot, 1'b1};
                  add_due(typed_word);
               end
            end else begin
               foreach (slot_hits[k]) add_due(slot_hits[k]);
            end
            idle_between();
         end
      end

      run_phase(16'd0, 8'hFF, 16'($urandom), $urandom, 40, 1'b1);
      run_phase(16'hFFFF, 8'hFF, 16'hFFFF, 32'hFFFF_0000, 35, 1'b0);
      run_phase(16'($urandom_range(1, 60)), 8'($urandom), 16'($urandom), $urandom, 45, 1'b0);
      run_phase(16'd1, 8'hFF, 16'h0000, 32'd0, 40, 1'b0);
      run_phase(16'($urandom), 8'hFF, 16'($urandom), $urandom, 50, 1'b0);

      settle_block();
      if (mismatches == 0 && events_due.size() == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule
